>>> design/hciq_pkg.sv
// ----------------------------------------------------------------------------
// hciq_pkg
// Types, clipping bounds and the reciprocal table that the stages of the
// H.263 intra coefficient quantiser share.
// ----------------------------------------------------------------------------
package hciq_pkg;

	// Clipping bounds, held as magnitudes.
	localparam logic [11:0] DC_LEVEL_MAX   = 12'd255;
	localparam logic [11:0] DC_LEVEL_MIN   = 12'd1;
	localparam logic [10:0] AC_NORM_POS    = 11'd127;
	localparam logic [10:0] AC_NORM_NEG_Q  = 11'd127;
	localparam logic [10:0] AC_NORM_NEG_IQ = 11'd128;
	localparam logic [10:0] AC_MOD_POS     = 11'd1023;
	localparam logic [10:0] AC_MOD_NEG     = 11'd1024;
	localparam logic [16:0] REC_POS_MAX    = 17'd2047;
	localparam logic [16:0] REC_NEG_MAX    = 17'd2048;
	localparam logic [11:0] DC_REC_MAX     = 12'd2047;

	// Reciprocal bits below the binary point of the quantiser estimate.
	localparam int unsigned RECIP_FRAC = 16;

	typedef enum logic {
		CMD_QUANT   = 1'b0,
		CMD_INVERSE = 1'b1
	} cmd_t;

	// Payload leaving the decode stage.
	typedef struct packed {
		cmd_t        cmd;
		logic        direct_en;
		logic        neg;
		logic        mode;
		logic [4:0]  q;
		logic [11:0] opnd;
		logic [15:0] recip;
		logic [11:0] direct;
	} s1_t;

	// Payload leaving the multiply stage.
	typedef struct packed {
		cmd_t        cmd;
		logic        direct_en;
		logic        neg;
		logic        mode;
		logic [4:0]  q;
		logic [11:0] opnd;
		logic [27:0] prod;
		logic [11:0] direct;
	} s2_t;

	// Payload leaving the correction stage.
	typedef struct packed {
		cmd_t        cmd;
		logic        direct_en;
		logic        neg;
		logic        mode;
		logic [4:0]  q;
		logic [11:0] opnd;
		logic [16:0] val;
		logic [11:0] qd;
		logic [11:0] direct;
	} s3_t;

	// floor(2^16 / (2q)); a step of zero is read as a step of one.
	function automatic logic [15:0] hciq_recip(input logic [4:0] q);
		logic [15:0] r;
		unique case (q)
			5'd0:  r = 16'd32768;
			5'd1:  r = 16'd32768;
			5'd2:  r = 16'd16384;
			5'd3:  r = 16'd10922;
			5'd4:  r = 16'd8192;
			5'd5:  r = 16'd6553;
			5'd6:  r = 16'd5461;
			5'd7:  r = 16'd4681;
			5'd8:  r = 16'd4096;
			5'd9:  r = 16'd3640;
			5'd10: r = 16'd3276;
			5'd11: r = 16'd2978;
			5'd12: r = 16'd2730;
			5'd13: r = 16'd2520;
			5'd14: r = 16'd2340;
			5'd15: r = 16'd2184;
			5'd16: r = 16'd2048;
			5'd17: r = 16'd1927;
			5'd18: r = 16'd1820;
			5'd19: r = 16'd1724;
			5'd20: r = 16'd1638;
			5'd21: r = 16'd1560;
			5'd22: r = 16'd1489;
			5'd23: r = 16'd1424;
			5'd24: r = 16'd1365;
			5'd25: r = 16'd1310;
			5'd26: r = 16'd1260;
			5'd27: r = 16'd1213;
			5'd28: r = 16'd1170;
			5'd29: r = 16'd1129;
			5'd30: r = 16'd1092;
			5'd31: r = 16'd1057;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction

endpackage

>>> design/hciq_in_if.sv
// ----------------------------------------------------------------------------
// hciq_in_if
// Input channel: one coefficient or level per item.
// ----------------------------------------------------------------------------
interface hciq_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic               dc_flag;
	logic [4:0]         step_size;
	logic signed [11:0] coeff_in;

	modport source (output valid, command, dc_flag, step_size, coeff_in, input ready);
	modport sink   (input valid, command, dc_flag, step_size, coeff_in, output ready);
endinterface

>>> design/hciq_out_if.sv
// ----------------------------------------------------------------------------
// hciq_out_if
// Output channel: one quantised level or reconstructed coefficient per item.
// ----------------------------------------------------------------------------
interface hciq_out_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] coeff_out;

	modport source (output valid, coeff_out, input ready);
	modport sink   (input valid, coeff_out, output ready);
endinterface

>>> design/hciq_cfg_if.sv
// ----------------------------------------------------------------------------
// hciq_cfg_if
// Configuration write channel for the modified quantisation mode register.
// ----------------------------------------------------------------------------
interface hciq_cfg_if;
	logic valid;
	logic ready;
	logic modified_mode;

	modport source (output valid, modified_mode, input ready);
	modport sink   (input valid, modified_mode, output ready);
endinterface

>>> design/h263_intra_coeff_quantiser_top.sv
// ----------------------------------------------------------------------------
// h263_intra_coeff_quantiser_top
// Throughput: one item per cycle while the output side is ready, set by
// the four-stage pipeline with one shared multiplier in its second stage;
// each stage stalls only while it is full and the next one is not ready.
// Reset: arst_n clears every stage valid bit and the mode register to normal.
// ----------------------------------------------------------------------------
module h263_intra_coeff_quantiser_top import hciq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hciq_cfg_if.sink   cfg,
	hciq_in_if.sink    req,
	hciq_out_if.source rsp
);

	// Modified quantisation mode. Writes must arrive only while the pipeline is
	// empty (not enforced by the block); each item picks up the value at its entry.
	logic mode_q;

	// Handshake between neighbouring stages.
	logic v1, r1, v2, r2, v3, r3;
	s1_t  d1;
	s2_t  d2;
	s3_t  d3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.modified_mode;
		end
	end

	// Stage one: magnitude and sign, the DC and zero-level results, which
	// need no arithmetic beyond shifts, and the level clip for reconstruction.
	hciq_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.command   (req.command),
		.dc_flag   (req.dc_flag),
		.step_size (req.step_size),
		.coeff_in  (req.coeff_in),
		.out_valid (v1),
		.out_ready (r1),
		.out_data  (d1)
	);

	// Stage two: the division by 2q is done as a multiplication by a tabled
	// reciprocal; the same multiplier forms q*(2|level|+1) for reconstruction.
	hciq_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2)
	);

	// Stage three: the reciprocal estimate may fall one short of the true
	// quotient, so it is multiplied back by the divisor for a remainder check.
	hciq_correct u_correct (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.out_valid (v3),
		.out_ready (r3),
		.out_data  (d3)
	);

	// Stage four: remainder correction, clipping to the range of the case
	// and mode, and the sign. Its register is the output register.
	hciq_output u_output (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r3),
		.in_data   (d3),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.coeff_out (rsp.coeff_out)
	);

endmodule

>>> design/hciq_decode.sv
// ----------------------------------------------------------------------------
// hciq_decode
// First stage: takes the magnitude, settles the DC and zero-level cases and
// prepares the multiplier operands.
// ----------------------------------------------------------------------------
module hciq_decode import hciq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic               dc_flag,
	input  logic [4:0]         step_size,
	input  logic signed [11:0] coeff_in,
	output logic               out_valid,
	input  logic               out_ready,
	output s1_t                out_data
);

	logic        valid_s1;
	s1_t         data_s1;
	s1_t         nxt;
	logic [4:0]  q_eff;
	logic        neg;
	logic [11:0] mag;
	logic [8:0]  mag_div8;
	logic [10:0] lim;
	logic [10:0] lvl;
	logic [11:0] dc_q;
	logic [11:0] dc_iq;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_comb begin
		q_eff    = (step_size == 5'd0) ? 5'd1 : step_size;
		neg      = coeff_in[11];
		mag      = neg ? (~coeff_in + 12'd1) : coeff_in;
		mag_div8 = mag[11:3];

		// DC quantise: truncation toward zero, so any negative value clips up to one.
		if (neg || mag_div8 == 9'd0) begin
			dc_q = DC_LEVEL_MIN;
		end else if (mag_div8 > 9'(DC_LEVEL_MAX)) begin
			dc_q = DC_LEVEL_MAX;
		end else begin
			dc_q = {3'd0, mag_div8};
		end

		// DC reconstruction: eight times the level, never below zero.
		if (neg) begin
			dc_iq = 12'd0;
		end else if (mag[11:8] != 4'd0) begin
			dc_iq = DC_REC_MAX;
		end else begin
			dc_iq = {1'b0, mag[7:0], 3'd0};
		end

		// Level range of the current mode before reconstruction.
		if (neg) begin
			lim = mode ? AC_MOD_NEG : AC_NORM_NEG_IQ;
		end else begin
			lim = mode ? AC_MOD_POS : AC_NORM_POS;
		end
		lvl = (mag > {1'b0, lim}) ? lim : mag[10:0];

		nxt.cmd       = cmd_t'(command);
		nxt.neg       = neg;
		nxt.mode      = mode;
		nxt.q         = q_eff;
		nxt.recip     = hciq_recip(q_eff);
		nxt.direct_en = dc_flag || (command == CMD_INVERSE && mag == 12'd0);
		nxt.opnd      = (command == CMD_INVERSE) ? {lvl, 1'b1} : mag;
		if (!dc_flag) begin
			nxt.direct = 12'd0;
		end else begin
			nxt.direct = (command == CMD_INVERSE) ? dc_iq : dc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

>>> design/hciq_mult.sv
// ----------------------------------------------------------------------------
// hciq_mult
// Second stage: one shared multiplier, magnitude times reciprocal when
// quantising, odd level times step when reconstructing.
// ----------------------------------------------------------------------------
module hciq_mult import hciq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  s1_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output s2_t  out_data
);

	logic        valid_s2;
	s2_t         data_s2;
	s2_t         nxt;
	logic [15:0] factor;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_comb begin
		factor        = (in_data.cmd == CMD_INVERSE) ? {11'd0, in_data.q} : in_data.recip;
		nxt.cmd       = in_data.cmd;
		nxt.direct_en = in_data.direct_en;
		nxt.neg       = in_data.neg;
		nxt.mode      = in_data.mode;
		nxt.q         = in_data.q;
		nxt.opnd      = in_data.opnd;
		nxt.direct    = in_data.direct;
		nxt.prod      = 28'(in_data.opnd) * 28'(factor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

>>> design/hciq_correct.sv
// ----------------------------------------------------------------------------
// hciq_correct
// Third stage: quotient estimate times divisor for the remainder check, or
// the even-step adjustment of the reconstructed magnitude.
// ----------------------------------------------------------------------------
module hciq_correct import hciq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  s2_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output s3_t  out_data
);

	logic        valid_s3;
	s3_t         data_s3;
	s3_t         nxt;
	logic [11:0] q_est;
	logic [5:0]  divisor;
	logic [17:0] q_times_d;
	logic [16:0] rec_mag;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	always_comb begin
		q_est     = in_data.prod[RECIP_FRAC +: 12];
		divisor   = {in_data.q, 1'b0};
		q_times_d = 18'(q_est) * 18'(divisor);
		// An even step reconstructs one short in magnitude.
		rec_mag   = in_data.prod[16:0] - 17'(!in_data.q[0]);

		nxt.cmd       = in_data.cmd;
		nxt.direct_en = in_data.direct_en;
		nxt.neg       = in_data.neg;
		nxt.mode      = in_data.mode;
		nxt.q         = in_data.q;
		nxt.opnd      = in_data.opnd;
		nxt.direct    = in_data.direct;
		nxt.val       = (in_data.cmd == CMD_INVERSE) ? rec_mag : {5'd0, q_est};
		// The estimate never exceeds the true quotient, so this stays within the magnitude.
		nxt.qd        = q_times_d[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

endmodule

>>> design/hciq_output.sv
// ----------------------------------------------------------------------------
// hciq_output
// Fourth stage and output register: remainder correction, sign and clipping.
// ----------------------------------------------------------------------------
module hciq_output import hciq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  s3_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [11:0] coeff_out
);

	logic        valid_s4;
	logic [11:0] coeff_s4;
	logic [11:0] nxt;
	logic [5:0]  divisor;
	logic [11:0] rem;
	logic [11:0] q_true;
	logic [10:0] q_cap;
	logic [11:0] q_lim;
	logic [16:0] r_cap;
	logic [11:0] mag_res;

	assign in_ready  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;
	assign coeff_out = coeff_s4;

	always_comb begin
		divisor = {in_data.q, 1'b0};
		rem     = in_data.opnd - in_data.qd;
		q_true  = (rem >= {6'd0, divisor}) ? (in_data.val[11:0] + 12'd1) : in_data.val[11:0];

		if (in_data.neg) begin
			q_cap = in_data.mode ? AC_MOD_NEG : AC_NORM_NEG_Q;
			r_cap = REC_NEG_MAX;
		end else begin
			q_cap = in_data.mode ? AC_MOD_POS : AC_NORM_POS;
			r_cap = REC_POS_MAX;
		end
		q_lim = (q_true > {1'b0, q_cap}) ? {1'b0, q_cap} : q_true;

		if (in_data.cmd == CMD_INVERSE) begin
			mag_res = (in_data.val > r_cap) ? r_cap[11:0] : in_data.val[11:0];
		end else begin
			mag_res = q_lim;
		end

		if (in_data.direct_en) begin
			nxt = in_data.direct;
		end else if (in_data.neg) begin
			nxt = ~mag_res + 12'd1;
		end else begin
			nxt = mag_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			coeff_s4 <= nxt;
		end
	end

endmodule

>>> sim/h263_intra_coeff_quantiser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h263_intra_coeff_quantiser_top_test
// Self-checking bench for the intra coefficient quantiser: directed corner
// items in both level ranges, then random items with random pacing on both
// channels, each result compared with a behavioural prediction.
// ----------------------------------------------------------------------------
module h263_intra_coeff_quantiser_top_test;
	import hciq_pkg::*;

	// Pipeline depth from the head of the block, used only for the final settle.
	localparam int LATENCY      = 4;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 800;
	localparam int RANDOM_PHASES = 4;

	// One accepted item together with the coefficient it should produce.
	typedef struct {
		cmd_t               cmd;
		logic               dc;
		logic [4:0]         step;
		logic signed [11:0] coeff;
		logic signed [11:0] level;
	} quant_item_t;

	logic clk = 1'b0;
	logic arst_n;

	hciq_cfg_if cfg_ch ();
	hciq_in_if  req_ch ();
	hciq_out_if rsp_ch ();

	h263_intra_coeff_quantiser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Results still owed by the block, oldest first.
	quant_item_t pending_levels[$];
	// Shadow of the mode register, updated when a write is accepted.
	logic        mode_shadow = 1'b0;
	int          mismatch_count = 0;
	// When set, the sender offers items back to back with no gaps.
	bit          sender_steady = 1'b0;

	// A 12 ns clock: six nanoseconds high, six low.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Behavioural prediction of one result. Division in SystemVerilog truncates
	// toward zero, which is exactly the rounding the quantiser uses.
	function automatic logic signed [11:0] predict_coeff(input cmd_t cmd, input logic dc,
			input logic [4:0] step, input logic signed [11:0] coeff, input logic mode);
		int q;
		int v;
		int mag;
		int r;
		// A zero step is read as a step of one.
		q = (step == 5'd0) ? 1 : int'(step);
		v = int'(coeff);
		if (cmd == CMD_QUANT) begin
			if (dc)
				r = clamp_int(v / 8, 1, 255);
			else if (mode)
				r = clamp_int(v / (2 * q), -1024, 1023);
			else
				r = clamp_int(v / (2 * q), -127, 127);
		end else if (dc) begin
			r = clamp_int(8 * v, 0, 2047);
		end else if (v == 0) begin
			r = 0;
		end else begin
			// The level is limited to the table range of the mode first; the
			// normal range is one wider on the negative side than when quantising.
			v = mode ? clamp_int(v, -1024, 1023) : clamp_int(v, -128, 127);
			mag = q * (2 * (v < 0 ? -v : v) + 1);
			if (q % 2 == 0)
				mag = mag - 1;
			r = clamp_int(v < 0 ? -mag : mag, -2048, 2047);
		end
		return r[11:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Gap lengths: mostly none or short, now and then a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Coefficients are drawn so that the clipping bounds and the full-scale
	// values turn up far more often than a flat draw would give them.
	function automatic int pick_coeff();
		int roll;
		int bound;
		int v;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			v = int'($urandom_range(0, 4095)) - 2048;
		end else if (roll < 65) begin
			v = int'($urandom_range(0, 600)) - 300;
		end else if (roll < 80) begin
			v = $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 15))
			                         : -2048 + int'($urandom_range(0, 15));
		end else begin
			bound = $urandom_range(0, 1) ? 1024 : 128;
			v = bound + int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	// Offers one item after a random gap and returns at the edge that takes it.
	// Valid is left high, so the next item can follow without a bubble.
	task automatic send_coeff(input cmd_t cmd, input logic dc, input logic [4:0] step,
			input int coeff);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.command   <= cmd;
		req_ch.dc_flag   <= dc;
		req_ch.step_size <= step;
		req_ch.coeff_in  <= coeff[11:0];
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	// Holds the sender back until every owed result has come out. The count
	// is looked at on the falling edge, once the monitor has recorded every
	// item taken at the rising edge before it, and the task returns on a
	// rising edge so that the caller drives at the edge as usual.
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_levels.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// The mode register is only written while the pipeline is empty.
	task automatic write_mode(input logic mode);
		wait_until_drained();
		cfg_ch.valid         <= 1'b1;
		cfg_ch.modified_mode <= mode;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// Corner items shared by both level ranges: clipping at every bound,
	// truncation toward zero, even and odd steps, a zero step, a zero level,
	// the most negative level and negative DC terms.
	task automatic send_corner_items();
		send_coeff(CMD_QUANT,   1'b1, 5'd1,  -2048);
		send_coeff(CMD_QUANT,   1'b1, 5'd31,  2047);
		send_coeff(CMD_QUANT,   1'b0, 5'd1,   2047);
		send_coeff(CMD_QUANT,   1'b0, 5'd0,  -2048);
		send_coeff(CMD_QUANT,   1'b0, 5'd31,   -61);
		send_coeff(CMD_QUANT,   1'b0, 5'd2,   2047);
		send_coeff(CMD_INVERSE, 1'b1, 5'd0,   2047);
		send_coeff(CMD_INVERSE, 1'b1, 5'd17,    -1);
		send_coeff(CMD_INVERSE, 1'b0, 5'd31,     0);
		send_coeff(CMD_INVERSE, 1'b0, 5'd2,  -2048);
		send_coeff(CMD_INVERSE, 1'b0, 5'd1,   -128);
		send_coeff(CMD_INVERSE, 1'b0, 5'd0,      1);
		send_coeff(CMD_INVERSE, 1'b0, 5'd31,  2047);
	endtask

	// Corner items with the mode register as it comes out of reset.
	task automatic test_normal_range_corners();
		send_corner_items();
	endtask

	// The same corners again once the modified range has been selected.
	task automatic test_modified_range_corners();
		write_mode(1'b1);
		send_corner_items();
	endtask

	// Random items in several phases, the mode rewritten before each one.
	// Each rewrite first drains the pipeline, so the sender also sees the
	// block run completely empty several times.
	task automatic test_random_items();
		int phase;
		int i;
		cmd_t cmd;
		logic dc;
		logic [4:0] step;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_mode((phase == 1 || phase == 2) ? 1'b1 : 1'b0);
			for (i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
				// Now and then a stretch of back-to-back items.
				if (i % 40 == 0)
					sender_steady = ($urandom_range(0, 3) == 0);
				cmd  = cmd_t'($urandom_range(0, 1));
				dc   = ($urandom_range(0, 3) == 0);
				step = 5'($urandom_range(0, 31));
				send_coeff(cmd, dc, step, pick_coeff());
			end
			sender_steady = 1'b0;
		end
	endtask

	// Waits for every owed result, lets the pipeline settle so that a stray
	// extra result would still be caught, then gives the verdict.
	task automatic finish_run();
		wait_until_drained();
		repeat (4 * LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	endtask

	// Stimulus: reset once, then the tests in turn.
	initial begin
		arst_n               <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.modified_mode <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.command       <= CMD_QUANT;
		req_ch.dc_flag       <= 1'b0;
		req_ch.step_size     <= 5'd1;
		req_ch.coeff_in      <= 12'sd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_normal_range_corners();
		test_modified_range_corners();
		test_random_items();
		finish_run();
	end

	// The result side takes items in runs of random length separated by
	// random stalls; the occasional very long run leaves the block unhindered.
	initial begin : result_pacing
		int run_len;
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                      : $urandom_range(1, 12);
			rsp_ch.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Monitor for all three channels. Everything is sampled at the rising edge,
	// before any value driven at that edge takes effect. A mode write and the
	// item that follows it are handled in that order, and an item accepted is
	// recorded before a result at the same edge is checked, so the outcome does
	// not hang on the order in which processes wake.
	always @(posedge clk) begin : result_check
		quant_item_t owed;
		if (arst_n === 1'b1) begin
			if (cfg_ch.valid && cfg_ch.ready)
				mode_shadow = cfg_ch.modified_mode;
			if (req_ch.valid && req_ch.ready) begin
				owed.cmd   = cmd_t'(req_ch.command);
				owed.dc    = req_ch.dc_flag;
				owed.step  = req_ch.step_size;
				owed.coeff = req_ch.coeff_in;
				owed.level = predict_coeff(owed.cmd, owed.dc, owed.step, owed.coeff,
				                           mode_shadow);
				pending_levels.push_back(owed);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_levels.size() == 0) begin
					report_mismatch($sformatf("result %0d with no item outstanding",
					                          rsp_ch.coeff_out));
				end else begin
					owed = pending_levels.pop_front();
					if (rsp_ch.coeff_out !== owed.level)
						report_mismatch($sformatf(
							"%s dc=%0b q=%0d in=%0d mode=%0b: coeff_out %0d, wanted %0d",
							owed.cmd.name(), owed.dc, owed.step, owed.coeff, mode_shadow,
							rsp_ch.coeff_out, owed.level));
				end
			end
		end
	end

	// Watchdog: a correct run needs well under two milliseconds even with the
	// longest gaps on both sides, so twenty means the block has hung.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
